// File: hdl/gbp_pkg.sv
// shared types, screen geometry and the 5x7 font rom for the glyph blitter
// used by every module of glyph_blit_page_framebuffer; depends on nothing
package gbp_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES   = PAGE_COUNT * SCREEN_WIDTH;
    localparam int ADDR_W        = $clog2(STORE_BYTES);

    // command queue between front and engine
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // character codes
    localparam logic [7:0] FIRST_CODE    = 8'd32;
    localparam logic [7:0] LAST_CODE     = 8'd126;
    localparam logic [7:0] FALLBACK_CODE = 8'd63;

    // input mode codes
    localparam logic [1:0] MODE_DRAW  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // classified operation
    typedef enum logic [1:0] {
        OP_DRAW,
        OP_READ,
        OP_CLEAR,
        OP_ZERO
    } op_t;

    // one queued command; glyph holds column 0 in the top byte
    typedef struct packed {
        op_t               op;
        logic [39:0]       glyph;
        logic [7:0]        pos_x;
        logic [6:0]        pos_y;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

    // engine status seen by the front
    typedef struct packed {
        logic init_busy;
    } eng_status_t;

    // five glyph columns, column 0 in bits 39:32, bit 0 of each byte is the top row
    function automatic logic [39:0] glyph_bits(input logic [6:0] idx);
        logic [39:0] g;
        case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00005F0000;
            7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147F147F14;
            7'd4:  g = 40'h242A7F2A12;
            7'd5:  g = 40'h2313086462;
            7'd6:  g = 40'h3649552250;
            7'd7:  g = 40'h0005030000;
            7'd8:  g = 40'h001C224100;
            7'd9:  g = 40'h0041221C00;
            7'd10: g = 40'h14083E0814;
            7'd11: g = 40'h08083E0808;
            7'd12: g = 40'h0050300000;
            7'd13: g = 40'h0808080808;
            7'd14: g = 40'h0060600000;
            7'd15: g = 40'h2010080402;
            7'd16: g = 40'h3E5149453E;
            7'd17: g = 40'h00427F4000;
            7'd18: g = 40'h6251494946;
            7'd19: g = 40'h2249494936;
            7'd20: g = 40'h1814127F10;
            7'd21: g = 40'h2F49494931;
            7'd22: g = 40'h3E49494932;
            7'd23: g = 40'h0171090503;
            7'd24: g = 40'h3649494936;
            7'd25: g = 40'h264949493E;
            7'd26: g = 40'h0036360000;
            7'd27: g = 40'h0056360000;
            7'd28: g = 40'h0814224100;
            7'd29: g = 40'h1414141414;
            7'd30: g = 40'h0041221408;
            7'd31: g = 40'h0201590906;
            7'd32: g = 40'h3E415D551E;
            7'd33: g = 40'h7E1111117E;
            7'd34: g = 40'h7F49494936;
            7'd35: g = 40'h3E41414122;
            7'd36: g = 40'h7F4141221C;
            7'd37: g = 40'h7F49494941;
            7'd38: g = 40'h7F09090901;
            7'd39: g = 40'h3E4149497A;
            7'd40: g = 40'h7F0808087F;
            7'd41: g = 40'h00417F4100;
            7'd42: g = 40'h2040413F01;
            7'd43: g = 40'h7F08142241;
            7'd44: g = 40'h7F40404040;
            7'd45: g = 40'h7F020C027F;
            7'd46: g = 40'h7F0408107F;
            7'd47: g = 40'h3E4141413E;
            7'd48: g = 40'h7F09090906;
            7'd49: g = 40'h3E4151215E;
            7'd50: g = 40'h7F09192946;
            7'd51: g = 40'h4649494931;
            7'd52: g = 40'h01017F0101;
            7'd53: g = 40'h3F4040403F;
            7'd54: g = 40'h1F2040201F;
            7'd55: g = 40'h3F4038403F;
            7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0708700807;
            7'd58: g = 40'h6151494543;
            7'd59: g = 40'h007F414100;
            7'd60: g = 40'h0204081020;
            7'd61: g = 40'h0041417F00;
            7'd62: g = 40'h0402010204;
            7'd63: g = 40'h4040404040;
            7'd64: g = 40'h0003050000;
            7'd65: g = 40'h2054545478;
            7'd66: g = 40'h7F48444438;
            7'd67: g = 40'h3844444420;
            7'd68: g = 40'h384444487F;
            7'd69: g = 40'h3854545418;
            7'd70: g = 40'h087E090102;
            7'd71: g = 40'h0C5252523E;
            7'd72: g = 40'h7F08040478;
            7'd73: g = 40'h00447D4000;
            7'd74: g = 40'h2040443D00;
            7'd75: g = 40'h7F10284400;
            7'd76: g = 40'h00417F4000;
            7'd77: g = 40'h7C04180478;
            7'd78: g = 40'h7C08040478;
            7'd79: g = 40'h3844444438;
            7'd80: g = 40'h7C14141408;
            7'd81: g = 40'h081414147C;
            7'd82: g = 40'h7C08040408;
            7'd83: g = 40'h4854545420;
            7'd84: g = 40'h043F444020;
            7'd85: g = 40'h3C4040207C;
            7'd86: g = 40'h1C2040201C;
            7'd87: g = 40'h3C4030403C;
            7'd88: g = 40'h4428102844;
            7'd89: g = 40'h0C5050503C;
            7'd90: g = 40'h4464544C44;
            7'd91: g = 40'h0008364100;
            7'd92: g = 40'h00007F0000;
            7'd93: g = 40'h0041360800;
            7'd94: g = 40'h0804081008;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

endpackage

// File: hdl/gbp_front.sv
// front end: input handshake, mode decode, code fallback and font lookup
// depends on gbp_pkg; feeds gbp_cmd_fifo
module gbp_front (
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           mode,
    input  logic [7:0]           glyph_code,
    input  logic [7:0]           pos_x,
    input  logic [6:0]           pos_y,
    input  logic [9:0]           byte_address,
    input  logic                 q_full,
    input  gbp_pkg::eng_status_t eng_status,
    output logic                 cmd_push,
    output gbp_pkg::cmd_t        cmd
);

    localparam int CMP_W = ((gbp_pkg::ADDR_W > 10) ? gbp_pkg::ADDR_W : 10) + 1;

    logic             code_ok;
    logic [7:0]       code_eff;
    logic [7:0]       rom_idx;
    logic [CMP_W-1:0] addr_ext;
    logic             addr_ok;

    // no items while the store is swept after reset
    assign full     = q_full || eng_status.init_busy;
    assign cmd_push = push && !full;

    // unprintable codes fall back to the question mark
    assign code_ok  = (glyph_code >= gbp_pkg::FIRST_CODE) && (glyph_code <= gbp_pkg::LAST_CODE);
    assign code_eff = code_ok ? glyph_code : gbp_pkg::FALLBACK_CODE;
    assign rom_idx  = code_eff - gbp_pkg::FIRST_CODE;

    // reads beyond the store answer zero
    assign addr_ext = CMP_W'(byte_address);
    assign addr_ok  = addr_ext < CMP_W'(gbp_pkg::STORE_BYTES);

    // classify the word
    always_comb
    begin
        cmd.glyph = gbp_pkg::glyph_bits(rom_idx[6:0]);
        cmd.pos_x = pos_x;
        cmd.pos_y = pos_y;
        cmd.addr  = gbp_pkg::ADDR_W'(addr_ext);
        case (mode)
            gbp_pkg::MODE_DRAW:  cmd.op = gbp_pkg::OP_DRAW;
            gbp_pkg::MODE_READ:  cmd.op = addr_ok ? gbp_pkg::OP_READ : gbp_pkg::OP_ZERO;
            gbp_pkg::MODE_CLEAR: cmd.op = gbp_pkg::OP_CLEAR;
            default:             cmd.op = gbp_pkg::OP_ZERO;
        endcase
    end

endmodule

// File: hdl/gbp_cmd_fifo.sv
// short command queue between the front end and the engine
// depends on gbp_pkg
module gbp_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  gbp_pkg::cmd_t wr_cmd,
    output logic          q_full,
    input  logic          rd_en,
    output gbp_pkg::cmd_t rd_cmd,
    output logic          q_empty
);

    gbp_pkg::cmd_t                    slot_reg [gbp_pkg::CMD_DEPTH];
    logic [gbp_pkg::CMD_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [gbp_pkg::CMD_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [gbp_pkg::CMD_CNT_W-1:0]    count_reg, count_next;
    logic                             do_wr, do_rd;

    assign q_full  = count_reg == gbp_pkg::CMD_CNT_W'(gbp_pkg::CMD_DEPTH);
    assign q_empty = count_reg == '0;
    assign rd_cmd  = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == gbp_pkg::CMD_PTR_W'(gbp_pkg::CMD_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == gbp_pkg::CMD_PTR_W'(gbp_pkg::CMD_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: hdl/gbp_engine.sv
// back end: frame store memory, glyph read-modify-write sequencer, clear sweep
// and the result register; depends on gbp_pkg, fed by gbp_cmd_fifo
module gbp_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  gbp_pkg::cmd_t        q_cmd,
    output logic                 q_pop,
    output gbp_pkg::eng_status_t eng_status,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           read_data
);

    localparam int AW = gbp_pkg::ADDR_W;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_STEP,
        S_WRITE,
        S_READ,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    gbp_pkg::cmd_t   cmd_reg, cmd_next;
    logic [39:0]     glyph_reg, glyph_next;
    logic [2:0]      col_idx_reg, col_idx_next;
    logic            page_sel_reg, page_sel_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_data_reg, out_data_next;

    logic [7:0]      frame_mem [gbp_pkg::STORE_BYTES];
    logic [7:0]      rd_data_reg;

    logic [6:0]      col_bits;
    logic [8:0]      col_cur;
    logic [4:0]      page_cur;
    logic            col_ok;
    logic [7:0]      row_ok;
    logic [15:0]     mask16, data16;
    logic [7:0]      byte_mask, byte_data;
    logic [13:0]     draw_addr_wide;
    logic [AW-1:0]   draw_addr;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic            last_step;
    logic            clr_last;

    assign eng_status.init_busy = state_reg == S_INIT;
    assign empty                = !out_valid_reg;
    assign read_data            = out_data_reg;
    assign q_pop                = (state_reg == S_IDLE) && !q_empty;

    // current glyph column and the page byte it touches
    assign col_bits = glyph_reg[38:32];
    assign col_cur  = 9'(cmd_reg.pos_x) + 9'(col_idx_reg);
    assign page_cur = 5'(cmd_reg.pos_y[6:3]) + 5'(page_sel_reg);
    assign col_ok   = col_cur < 9'(gbp_pkg::SCREEN_WIDTH);
    assign mask16   = 16'(8'h7F) << cmd_reg.pos_y[2:0];
    assign data16   = 16'(col_bits) << cmd_reg.pos_y[2:0];

    // rows past the bottom edge are clipped
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            row_ok[b] = {1'b0, page_cur, 3'(b)} < 9'(gbp_pkg::SCREEN_HEIGHT);
        end
    end

    assign byte_mask = (page_sel_reg ? mask16[15:8] : mask16[7:0]) & row_ok & {8{col_ok}};
    assign byte_data = page_sel_reg ? data16[15:8] : data16[7:0];

    assign draw_addr_wide = 14'(page_cur) * 14'(gbp_pkg::SCREEN_WIDTH) + 14'(col_cur);
    assign draw_addr      = AW'(draw_addr_wide);

    assign last_step = (col_idx_reg == 3'd4) && page_sel_reg;
    assign clr_last  = clr_cnt_reg == AW'(gbp_pkg::STORE_BYTES - 1);

    // memory port selection
    assign rd_addr = (cmd_reg.op == gbp_pkg::OP_READ) ? cmd_reg.addr : draw_addr;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = 8'h00;
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            S_WRITE:
            begin
                wr_en   = 1'b1;
                wr_addr = draw_addr;
                wr_data = (rd_data_reg & ~byte_mask) | (byte_data & byte_mask);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        glyph_next     = glyph_reg;
        col_idx_next   = col_idx_reg;
        page_sel_next  = page_sel_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !pop;
        out_data_next  = out_data_reg;
        case (state_reg)
            S_INIT:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    cmd_next      = q_cmd;
                    glyph_next    = q_cmd.glyph;
                    col_idx_next  = 3'd0;
                    page_sel_next = 1'b0;
                    case (q_cmd.op)
                        gbp_pkg::OP_DRAW:  state_next = S_STEP;
                        gbp_pkg::OP_READ:  state_next = S_READ;
                        gbp_pkg::OP_CLEAR: state_next = S_CLEAR;
                        default:           state_next = S_DONE;
                    endcase
                end
            end
            S_STEP, S_WRITE:
            begin
                if ((state_reg == S_STEP) && (byte_mask != 8'h00))
                begin
                    // read issued this cycle, merge next cycle
                    state_next = S_WRITE;
                end
                else if (last_step)
                begin
                    state_next = S_DONE;
                end
                else if (!page_sel_reg)
                begin
                    page_sel_next = 1'b1;
                    state_next    = S_STEP;
                end
                else
                begin
                    page_sel_next = 1'b0;
                    col_idx_next  = col_idx_reg + 1'b1;
                    glyph_next    = {glyph_reg[31:0], 8'h00};
                    state_next    = S_STEP;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    clr_cnt_next = '0;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = (cmd_reg.op == gbp_pkg::OP_READ) ? rd_data_reg : 8'h00;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            col_idx_reg   <= '0;
            page_sel_reg  <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_idx_reg   <= col_idx_next;
            page_sel_reg  <= page_sel_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        glyph_reg    <= glyph_next;
        out_data_reg <= out_data_next;
    end

    // frame store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

endmodule

// File: hdl/glyph_blit_page_framebuffer.sv
// glyph draw: over five columns, a read-modify-write of each page byte the glyph touches
// (at most two pages under each column); read: one registered store read;
// clear: the whole store, one byte written per cycle.
// a 2-deep command queue takes new words while the engine works and a result waits.
// after reset the store is swept to zero, all STORE_BYTES bytes (1024 at 128x64),
// with full held high. depends on gbp_pkg, gbp_front, gbp_cmd_fifo, gbp_engine
module glyph_blit_page_framebuffer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] mode,
    input  logic [7:0] glyph_code,
    input  logic [7:0] pos_x,
    input  logic [6:0] pos_y,
    input  logic [9:0] byte_address,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] read_data
);

    gbp_pkg::cmd_t        front_cmd;
    gbp_pkg::cmd_t        head_cmd;
    gbp_pkg::eng_status_t eng_status;
    logic                 front_push;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;

    // accept and classify
    gbp_front u_front (
        .push         (push),
        .full         (full),
        .mode         (mode),
        .glyph_code   (glyph_code),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .byte_address (byte_address),
        .q_full       (q_full),
        .eng_status   (eng_status),
        .cmd_push     (front_push),
        .cmd          (front_cmd)
    );

    // decoupling queue
    gbp_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_cmd  (front_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (head_cmd),
        .q_empty (q_empty)
    );

    // execute against the frame store
    gbp_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_cmd      (head_cmd),
        .q_pop      (q_pop),
        .eng_status (eng_status),
        .empty      (empty),
        .pop        (pop),
        .read_data  (read_data)
    );

endmodule

// File: tb/tb.sv
// self-checking testbench for glyph_blit_page_framebuffer: a directed table, a back-pressure burst,
// then random words checked against a shadow framebuffer and a private copy of the 5x7 font
// depends on gbp_pkg and the glyph_blit_page_framebuffer rtl
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // mode 3 is left unused by the block and must read back zero
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int TARGET_WORDS = 450;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RX_HOLD_LONG = 150;
    localparam int MAX_PRINTED  = 100;

    // font columns, column 0 in bits 39:32, bit 0 of each byte is the top row
    localparam logic [39:0] FONT_COLS [0:94] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
        40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h6251494946, 40'h2249494936,
        40'h1814127F10, 40'h2F49494931, 40'h3E49494932, 40'h0171090503, 40'h3649494936,
        40'h264949493E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201590906, 40'h3E415D551E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
        40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
        40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414147C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
        40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804081008
    };

    // one row of the directed table; known rows carry a hand-typed read_data
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] code;
        logic [7:0] x;
        logic [6:0] y;
        logic [9:0] addr;
        logic       known;
        logic [7:0] want;
    } row_t;

    localparam int DIRECTED_ROWS = 26;

    // reads after reset, fonts at the code limits, clipping at both edges, mode 3, clear
    row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd0,    1'b1, 8'h00},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd1023, 1'b1, 8'h00},
        '{gbp_pkg::MODE_DRAW,  8'd48,  8'd0,   7'd0,   10'd1023, 1'b1, 8'h00},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd0,    1'b1, 8'h3E},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd2,    1'b1, 8'h49},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd4,    1'b1, 8'h3E},
        '{gbp_pkg::MODE_DRAW,  8'd0,   8'd10,  7'd0,   10'd0,    1'b1, 8'h00},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd12,   1'b1, 8'h59},
        '{gbp_pkg::MODE_DRAW,  8'd127, 8'd20,  7'd0,   10'd0,    1'b1, 8'h00},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd20,   1'b1, 8'h02},
        '{gbp_pkg::MODE_DRAW,  8'd255, 8'd30,  7'd3,   10'd0,    1'b1, 8'h00},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd32,   1'b0, 8'h00},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd160,  1'b0, 8'h00},
        '{gbp_pkg::MODE_DRAW,  8'd75,  8'd40,  7'd8,   10'd0,    1'b1, 8'h00},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd168,  1'b1, 8'h7F},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd171,  1'b1, 8'h22},
        '{gbp_pkg::MODE_DRAW,  8'd126, 8'd125, 7'd60,  10'd0,    1'b1, 8'h00},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd1021, 1'b0, 8'h00},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd1023, 1'b0, 8'h00},
        '{gbp_pkg::MODE_DRAW,  8'd32,  8'd0,   7'd0,   10'd0,    1'b1, 8'h00},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd0,    1'b1, 8'h00},
        '{gbp_pkg::MODE_DRAW,  8'd255, 8'd255, 7'd127, 10'd1023, 1'b1, 8'h00},
        '{MODE_SPARE,          8'd255, 8'd255, 7'd127, 10'd1023, 1'b1, 8'h00},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd896,  1'b0, 8'h00},
        '{gbp_pkg::MODE_CLEAR, 8'd255, 8'd255, 7'd127, 10'd1023, 1'b1, 8'h00},
        '{gbp_pkg::MODE_READ,  8'd0,   8'd0,   7'd0,   10'd168,  1'b1, 8'h00}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic [1:0] mode = 2'd0;
    logic [7:0] glyph_code = 8'd0;
    logic [7:0] pos_x = 8'd0;
    logic [6:0] pos_y = 7'd0;
    logic [9:0] byte_address = 10'd0;
    logic       full;
    logic       empty;
    logic [7:0] read_data;

    // shadow framebuffer and the read_data bytes still owed by the block
    logic [7:0] shadow_fb [gbp_pkg::STORE_BYTES];
    logic [7:0] due_bytes [$];

    bit zero_idle = 1'b0;
    int rx_hold_cycles = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int n_words = 0;
    int n_draws = 0;
    int n_clipped = 0;
    int n_reads = 0;
    int n_clears = 0;
    int n_spare = 0;
    int n_checked = 0;
    int last_x = 0;
    int last_y = 0;

    glyph_blit_page_framebuffer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .glyph_code   (glyph_code),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .byte_address (byte_address),
        .empty        (empty),
        .pop          (pop),
        .read_data    (read_data)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        return zero_idle ? 0 : int'($urandom_range(0, 8));
    endfunction

    // apply one word to the shadow framebuffer and return the read_data it yields
    function automatic logic [7:0] apply_word(input logic [1:0] m, input logic [7:0] code,
                                              input logic [7:0] x, input logic [6:0] y,
                                              input logic [9:0] a);
        int idx;
        int col;
        int row;
        logic [7:0] column_bits;
        logic [7:0] data;
        data = 8'h00;
        case (m)
            gbp_pkg::MODE_DRAW:
            begin
                if (code < gbp_pkg::FIRST_CODE || code > gbp_pkg::LAST_CODE)
                    idx = int'(gbp_pkg::FALLBACK_CODE) - int'(gbp_pkg::FIRST_CODE);
                else
                    idx = int'(code) - int'(gbp_pkg::FIRST_CODE);
                for (int dx = 0; dx < 5; dx++)
                begin
                    column_bits = FONT_COLS[idx][39 - 8*dx -: 8];
                    for (int dy = 0; dy < 7; dy++)
                    begin
                        col = int'(x) + dx;
                        row = int'(y) + dy;
                        // every glyph pixel is written, lit or dark, unless off screen
                        if (col < gbp_pkg::SCREEN_WIDTH && row < gbp_pkg::SCREEN_HEIGHT)
                            shadow_fb[(row / 8) * gbp_pkg::SCREEN_WIDTH + col][row % 8] =
                                column_bits[dy];
                    end
                end
            end
            gbp_pkg::MODE_READ:
            begin
                if (int'(a) < gbp_pkg::STORE_BYTES)
                    data = shadow_fb[a];
            end
            gbp_pkg::MODE_CLEAR:
            begin
                foreach (shadow_fb[i])
                    shadow_fb[i] = 8'h00;
            end
            default:
            begin
            end
        endcase
        return data;
    endfunction

    // offer one word, wait for it to be taken, then log what it must return
    task automatic send_word(input logic [1:0] m, input logic [7:0] code, input logic [7:0] x,
                             input logic [6:0] y, input logic [9:0] a, input logic known,
                             input logic [7:0] want, input int gap);
        logic [7:0] predicted;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push         <= 1'b1;
        mode         <= m;
        glyph_code   <= code;
        pos_x        <= x;
        pos_y        <= y;
        byte_address <= a;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predicted = apply_word(m, code, x, y, a);
        due_bytes.push_back(known ? want : predicted);
        n_words++;
        case (m)
            gbp_pkg::MODE_DRAW:
            begin
                n_draws++;
                last_x = int'(x);
                last_y = int'(y);
                if (int'(x) + 4 >= gbp_pkg::SCREEN_WIDTH || int'(y) + 6 >= gbp_pkg::SCREEN_HEIGHT)
                    n_clipped++;
            end
            gbp_pkg::MODE_READ:  n_reads++;
            gbp_pkg::MODE_CLEAR: n_clears++;
            default:             n_spare++;
        endcase
        @(negedge clk);
    endtask

    // a byte under or just below the last glyph drawn, or anywhere if that pixel is off screen
    function automatic logic [9:0] near_last_glyph();
        int col;
        int row;
        col = last_x + int'($urandom_range(0, 4));
        row = last_y + int'($urandom_range(0, 7));
        if (col < gbp_pkg::SCREEN_WIDTH && row < gbp_pkg::SCREEN_HEIGHT)
            return 10'((row / 8) * gbp_pkg::SCREEN_WIDTH + col);
        return 10'($urandom_range(0, 1023));
    endfunction

    task automatic send_random_draw(input int gap);
        logic [7:0] code;
        logic [7:0] x;
        logic [6:0] y;
        code = ($urandom_range(0, 6) == 0)
             ? 8'($urandom_range(0, 255))
             : 8'($urandom_range(gbp_pkg::FIRST_CODE, gbp_pkg::LAST_CODE));
        x = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, gbp_pkg::SCREEN_WIDTH - 1));
        y = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(0, gbp_pkg::SCREEN_HEIGHT - 1));
        send_word(gbp_pkg::MODE_DRAW, code, x, y, 10'($urandom_range(0, 1023)), 1'b0, 8'h00,
                  gap);
    endtask

    // result side: random stalls, an occasional long hold-off, check against the oldest byte
    initial
    begin
        int stall;
        logic [7:0] want;
        @(negedge clk);
        forever
        begin
            stall = pick_gap();
            if (rx_hold_cycles > 0)
            begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            if (due_bytes.size() == 0)
                report_mismatch($sformatf("word popped with nothing due, read_data %02h",
                                          read_data));
            else
            begin
                want = due_bytes.pop_front();
                if (read_data !== want)
                    report_mismatch($sformatf("read_data %02h, expected %02h", read_data, want));
            end
            n_checked++;
            @(negedge clk);
        end
    end

    // run limit
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still due", cycle_count, due_bytes.size());
        $display("end of test: mismatches");
        $finish;
    end

    // stimulus
    initial
    begin
        int pick;
        int reads_after;
        foreach (shadow_fb[i])
            shadow_fb[i] = 8'h00;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table; full covers the sweep that runs after reset
        foreach (directed_rows[i])
            send_word(directed_rows[i].mode, directed_rows[i].code, directed_rows[i].x,
                      directed_rows[i].y, directed_rows[i].addr, directed_rows[i].known,
                      directed_rows[i].want, pick_gap());

        // back-pressure: receiver holds off while words keep coming
        rx_hold_cycles = RX_HOLD_LONG;
        send_random_draw(0);
        repeat (15)
            send_word(gbp_pkg::MODE_READ, 8'($urandom), 8'($urandom), 7'($urandom),
                      near_last_glyph(), 1'b0, 8'h00, 0);
        if (due_bytes.size() != 0)
        begin
            push <= 1'b0;
            while (due_bytes.size() != 0)
                @(negedge clk);
        end

        // random scenes: mostly a glyph followed by reads under it
        while (n_words < TARGET_WORDS)
        begin
            if (n_words % 60 == 0)
                zero_idle = ($urandom_range(0, 3) == 0);
            // sender pause until the block has drained
            if (n_words >= TARGET_WORDS / 2 && n_words < TARGET_WORDS / 2 + 6
                && due_bytes.size() != 0)
            begin
                push <= 1'b0;
                while (due_bytes.size() != 0)
                    @(negedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2)
                send_word(gbp_pkg::MODE_CLEAR, 8'($urandom), 8'($urandom), 7'($urandom),
                          10'($urandom), 1'b0, 8'h00, pick_gap());
            else if (pick < 5)
                send_word(MODE_SPARE, 8'($urandom), 8'($urandom), 7'($urandom), 10'($urandom),
                          1'b0, 8'h00, pick_gap());
            else if (pick < 12)
                send_word(gbp_pkg::MODE_READ, 8'($urandom), 8'($urandom), 7'($urandom),
                          10'($urandom), 1'b0, 8'h00, pick_gap());
            else
            begin
                send_random_draw(pick_gap());
                reads_after = $urandom_range(0, 4);
                repeat (reads_after)
                    send_word(gbp_pkg::MODE_READ, 8'($urandom), 8'($urandom), 7'($urandom),
                              near_last_glyph(), 1'b0, 8'h00, pick_gap());
            end
        end
        push <= 1'b0;

        // drain and settle
        while (due_bytes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d words: %0d draws (%0d at an edge), %0d reads, %0d clears, %0d mode 3",
                 n_words, n_draws, n_clipped, n_reads, n_clears, n_spare);
        $display("checked %0d read_data words in %0d cycles", n_checked, cycle_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
